### hdl/slbc_pkg.sv
// Shared types and constants for the status LED blink-code sequencer.
`default_nettype none
package slbc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CODE  = 2'd1,
    OP_PANEL = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Debug sequencer uses all four; panel sequencer uses idle, on-next, off-next.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CFG_PRESCALE = 3'd0,
    CFG_STEP     = 3'd1,
    CFG_ON       = 3'd2,
    CFG_OFF      = 3'd3,
    CFG_PAUSE    = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BLINK_W    = 9;

  localparam logic [7:0]  PRESCALE_RST = 8'hA4;
  localparam logic [7:0]  PRESCALE_CAP = 8'd254;
  localparam logic [15:0] STEP_RST     = 16'd100;
  localparam logic [7:0]  ON_RST       = 8'd18;
  localparam logic [7:0]  OFF_RST      = 8'd18;
  localparam logic [7:0]  PAUSE_RST    = 8'd80;
  localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

  typedef struct packed {
    logic        debug_led;
    logic        panel_led;
    logic [31:0] elapsed_us;
    logic [7:0]  current_code;
  } res_t;

endpackage
`default_nettype wire

### hdl/status_led_blink_code_sequencer.sv
// Status LED blink-code sequencer: tick/command words in, LED levels and time out.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_op, in_new_code, in_lit_time, in_dark_time
//  out_    | output    | out_valid/out_stall| out_debug_led, out_panel_led,
//          |           |                    | out_elapsed_us, out_current_code
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle while in_stall is low: state is updated in the accepting cycle
// and its result word is registered.
// A two-entry output stage (result register plus skid register) absorbs out_stall;
// in_stall rises only when both hold a word. Synchronous active-low reset
// restores the register defaults and the idle sequencer state, panel LED lit.
`default_nettype none
module status_led_blink_code_sequencer #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_op,
  input  wire logic [7:0]                     in_new_code,
  input  wire logic [7:0]                     in_lit_time,
  input  wire logic [7:0]                     in_dark_time,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_debug_led,
  output logic                                out_panel_led,
  output logic [31:0]                         out_elapsed_us,
  output logic [7:0]                          out_current_code,
  input  wire logic                           cfg_we,
  input  wire logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slbc_pkg::*;

  // configuration
  logic [7:0]  prescale_limit_r, code_on_ticks_r, code_off_ticks_r, code_pause_ticks_r;
  logic [15:0] time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_limit_r   <= PRESCALE_RST;
      time_step_r        <= STEP_RST;
      code_on_ticks_r    <= ON_RST;
      code_off_ticks_r   <= OFF_RST;
      code_pause_ticks_r <= PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRESCALE: prescale_limit_r   <= cfg_data[7:0];
        CFG_STEP:     time_step_r        <= cfg_data;
        CFG_ON:       code_on_ticks_r    <= cfg_data[7:0];
        CFG_OFF:      code_off_ticks_r   <= cfg_data[7:0];
        CFG_PAUSE:    code_pause_ticks_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [7:0]            prescale_count_r, prescale_count_nxt;
  phase_t                code_phase_r, code_phase_nxt;
  logic [7:0]            code_wait_r, code_wait_nxt;
  logic [BLINK_W-1:0]    blinks_done_r, blinks_done_nxt;
  logic [7:0]            code_value_r, code_value_nxt;
  logic                  debug_level_r, debug_level_nxt;
  phase_t                panel_phase_r, panel_phase_nxt;
  logic [7:0]            panel_wait_r, panel_wait_nxt;
  logic [7:0]            panel_on_len_r, panel_on_len_nxt;
  logic [7:0]            panel_off_len_r, panel_off_len_nxt;
  logic                  panel_level_r, panel_level_nxt;
  logic [TIME_WIDTH-1:0] time_count_r, time_count_nxt;

  logic       in_fire;
  op_t        op;
  logic [7:0] lim;
  logic       seq_step;
  logic       code_go;
  logic       panel_go;
  logic       code_done;

  assign in_fire   = in_valid && !in_stall;
  assign op        = op_t'(in_op);
  assign lim       = (prescale_limit_r > PRESCALE_CAP) ? PRESCALE_CAP : prescale_limit_r;
  assign seq_step  = in_fire && (op == OP_TICK) && (prescale_count_r > lim);
  assign code_go   = seq_step && (code_wait_r == 8'd0);
  assign panel_go  = seq_step && (panel_wait_r == 8'd0);
  assign code_done = blinks_done_r >= {1'b0, code_value_r};

  always_comb begin
    prescale_count_nxt = prescale_count_r;
    time_count_nxt     = time_count_r;
    if (in_fire && (op == OP_TICK)) begin
      time_count_nxt     = time_count_r + TIME_WIDTH'(time_step_r);
      prescale_count_nxt = seq_step ? 8'd0 : prescale_count_r + 8'd1;
    end
  end

  // debug sequencer: next phase
  always_comb begin
    code_phase_nxt = code_phase_r;
    if (code_go) begin
      unique case (code_phase_r)
        PH_ON:    code_phase_nxt = PH_OFF;
        PH_OFF:   code_phase_nxt = code_done ? PH_PAUSE : PH_ON;
        PH_PAUSE: code_phase_nxt = PH_ON;
        PH_IDLE:  code_phase_nxt = PH_IDLE;
      endcase
    end else if (in_fire && (op == OP_CODE)) begin
      priority if (in_new_code == 8'd0) code_phase_nxt = PH_IDLE;
      else if (in_new_code != code_value_r) code_phase_nxt = PH_OFF;
      else code_phase_nxt = code_phase_r;
    end
  end

  // debug sequencer: counters and level
  always_comb begin
    code_wait_nxt   = code_wait_r;
    blinks_done_nxt = blinks_done_r;
    debug_level_nxt = debug_level_r;
    code_value_nxt  = code_value_r;
    if (seq_step && (code_wait_r != 8'd0)) begin
      code_wait_nxt = code_wait_r - 8'd1;
    end else if (code_go) begin
      unique case (code_phase_r)
        PH_ON: begin
          if (blinks_done_r != BLINK_MAX) blinks_done_nxt = blinks_done_r + 1'b1;
          code_wait_nxt   = code_off_ticks_r;
          debug_level_nxt = 1'b0;
        end
        PH_OFF: begin
          if (code_done) begin
            code_wait_nxt = code_pause_ticks_r;
          end else begin
            code_wait_nxt   = code_on_ticks_r;
            debug_level_nxt = 1'b1;
          end
        end
        PH_PAUSE: begin
          blinks_done_nxt = '0;
          code_wait_nxt   = code_on_ticks_r;
          debug_level_nxt = 1'b1;
        end
        PH_IDLE: ;
      endcase
    end else if (in_fire && (op == OP_CODE)) begin
      code_value_nxt = in_new_code;
      if (in_new_code == 8'd0) debug_level_nxt = 1'b0;
    end
  end

  // panel sequencer: next phase
  always_comb begin
    panel_phase_nxt = panel_phase_r;
    if (panel_go) begin
      unique case (panel_phase_r)
        PH_ON:   panel_phase_nxt = PH_OFF;
        PH_OFF:  panel_phase_nxt = PH_ON;
        default: panel_phase_nxt = panel_phase_r;
      endcase
    end else if (in_fire && (op == OP_PANEL)) begin
      priority if ((in_dark_time == 8'd0) || (in_lit_time == 8'd0)) panel_phase_nxt = PH_IDLE;
      else panel_phase_nxt = PH_ON;
    end
  end

  // panel sequencer: counters and level
  always_comb begin
    panel_wait_nxt    = panel_wait_r;
    panel_level_nxt   = panel_level_r;
    panel_on_len_nxt  = panel_on_len_r;
    panel_off_len_nxt = panel_off_len_r;
    if (seq_step && (panel_wait_r != 8'd0)) begin
      panel_wait_nxt = panel_wait_r - 8'd1;
    end else if (panel_go) begin
      unique case (panel_phase_r)
        PH_ON: begin
          panel_wait_nxt  = panel_on_len_r;
          panel_level_nxt = 1'b1;
        end
        PH_OFF: begin
          panel_wait_nxt  = panel_off_len_r;
          panel_level_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (in_fire && (op == OP_PANEL)) begin
      priority if (in_dark_time == 8'd0) begin
        panel_level_nxt = 1'b1;
      end else if (in_lit_time == 8'd0) begin
        panel_level_nxt = 1'b0;
      end else begin
        panel_on_len_nxt  = in_lit_time;
        panel_off_len_nxt = in_dark_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_count_r <= 8'd0;
      code_phase_r     <= PH_IDLE;
      code_wait_r      <= 8'd0;
      blinks_done_r    <= '0;
      code_value_r     <= 8'd0;
      debug_level_r    <= 1'b0;
      panel_phase_r    <= PH_IDLE;
      panel_wait_r     <= 8'd0;
      panel_on_len_r   <= 8'd0;
      panel_off_len_r  <= 8'd0;
      panel_level_r    <= 1'b1;
      time_count_r     <= '0;
    end else begin
      prescale_count_r <= prescale_count_nxt;
      code_phase_r     <= code_phase_nxt;
      code_wait_r      <= code_wait_nxt;
      blinks_done_r    <= blinks_done_nxt;
      code_value_r     <= code_value_nxt;
      debug_level_r    <= debug_level_nxt;
      panel_phase_r    <= panel_phase_nxt;
      panel_wait_r     <= panel_wait_nxt;
      panel_on_len_r   <= panel_on_len_nxt;
      panel_off_len_r  <= panel_off_len_nxt;
      panel_level_r    <= panel_level_nxt;
      time_count_r     <= time_count_nxt;
    end
  end

  // result word and two-entry output stage
  logic [TIME_WIDTH+31:0] time_ext;
  res_t res;
  res_t out_word_r, skid_word_r;
  logic out_valid_r, skid_valid_r;
  logic out_fire;

  assign time_ext = {32'd0, time_count_nxt};
  assign res = '{debug_led:    debug_level_nxt,
                 panel_led:    panel_level_nxt,
                 elapsed_us:   time_ext[31:0],
                 current_code: code_value_nxt};

  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) skid_valid_r <= 1'b1;
      else out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_word_r <= skid_word_r;
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) skid_word_r <= res;
      else out_word_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_debug_led    = out_word_r.debug_led;
  assign out_panel_led    = out_word_r.panel_led;
  assign out_elapsed_us   = out_word_r.elapsed_us;
  assign out_current_code = out_word_r.current_code;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without a result word");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_fire) |=> (out_valid_r && !skid_valid_r))
    else $error("skid word not moved to result register");

  a_code_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op == OP_CODE) && (in_new_code == 8'd0))
      |=> ((code_phase_r == PH_IDLE) && !debug_level_r && (code_value_r == 8'd0)))
    else $error("code zero did not stop debug sequencer");
`endif

endmodule
`default_nettype wire
